// ===== rtl/sis_pkg.sv =====
// ----------------------------------------------------------------------------
// sis_pkg
// shared types for the stack insertion sorter: payloads and control groups
// ----------------------------------------------------------------------------
`default_nettype none

package sis_pkg;

  localparam int DATA_W = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     final_item;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     end_of_run;
    logic                     overflow;
  } out_item_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } sis_cmd_t;

  typedef struct packed {
    logic last_one;
  } sis_status_t;

endpackage

`default_nettype wire

// ===== rtl/sis_datapath.sv =====
// ----------------------------------------------------------------------------
// sis_datapath
// compare-and-shift cell chain holding the stack in descending order,
// fill count, drop flag and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module sis_datapath #(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sis_pkg::sis_cmd_t  cmd,
  input  wire sis_pkg::in_item_t  in_data,
  output sis_pkg::sis_status_t    status,
  output sis_pkg::out_item_t      out_data
);
  import sis_pkg::*;

  localparam int FILL_W = $clog2(DEPTH + 1);

  logic signed [DATA_W-1:0] cell_r   [DEPTH];
  logic signed [DATA_W-1:0] cell_nxt [DEPTH];
  logic [DEPTH-1:0]         lt;
  logic [FILL_W-1:0]        fill_r, fill_nxt;
  logic                     dropped_r, dropped_nxt;
  out_item_t                out_data_r;
  logic                     full;
  logic                     insert_ok;

  assign full      = (fill_r == FILL_W'(DEPTH));
  assign insert_ok = cmd.insert && !full;

  // cell i is occupied and holds a value smaller than the incoming one
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic shift_in;
    logic take_v;

    assign lt[i] = (FILL_W'(i) < fill_r) && (cell_r[i] < in_data.value);

    if (i == 0) begin : g_first
      assign shift_in = 1'b0;
    end else begin : g_rest
      assign shift_in = lt[i-1];
    end

    assign take_v = !shift_in && (lt[i] || (FILL_W'(i) == fill_r));

    always_comb begin
      cell_nxt[i] = cell_r[i];
      if (insert_ok) begin
        if (shift_in) begin
          if (i > 0) begin
            cell_nxt[i] = cell_r[(i > 0) ? i - 1 : 0];
          end
        end else if (take_v) begin
          cell_nxt[i] = in_data.value;
        end
      end else if (cmd.pop) begin
        if (i < DEPTH - 1) begin
          cell_nxt[i] = cell_r[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end

    always_ff @(posedge clk) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  always_comb begin
    fill_nxt    = fill_r;
    dropped_nxt = dropped_r;
    if (cmd.insert) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end else begin
        fill_nxt = fill_r + FILL_W'(1);
      end
    end else if (cmd.pop) begin
      if (status.last_one) begin
        fill_nxt    = '0;
        dropped_nxt = 1'b0;
      end else begin
        fill_nxt = fill_r - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      dropped_r <= 1'b0;
    end else begin
      fill_r    <= fill_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      out_data_r.sorted_value <= cell_r[0];
      out_data_r.end_of_run   <= status.last_one;
      out_data_r.overflow     <= dropped_r;
    end
  end

  assign status.last_one = (fill_r == FILL_W'(1));
  assign out_data        = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/sis_ctrl.sv =====
// ----------------------------------------------------------------------------
// sis_ctrl
// collect / emit sequencer and output valid flag
// ----------------------------------------------------------------------------
`default_nettype none

module sis_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_final,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire sis_pkg::sis_status_t status,
  output sis_pkg::sis_cmd_t         cmd
);
  import sis_pkg::*;

  localparam logic ST_COLLECT = 1'b0;
  localparam logic ST_EMIT    = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready   = (state_r == ST_COLLECT);
  assign cmd.insert = in_valid && in_ready;
  assign cmd.pop    = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (cmd.insert && in_final) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cmd.pop && status.last_one) begin
          state_nxt = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/stack_insertion_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// stack_insertion_sorter_unit
// collects signed values into a bounded sorted stack and emits them
// largest first once the set is closed
// ----------------------------------------------------------------------------
// usage:
//   in_valid / in_ready / in_data carry one value per transfer; in_ready is
//   high while the block collects. each value is placed by a
//   chain of DEPTH compare-and-shift cells, so collection runs at one
//   transfer per cycle. a value beyond DEPTH held entries is dropped and
//   marks the run as overflowed.
//   the transfer with final_item set closes the set. the block then emits
//   every held value on out_valid / out_ready / out_data, largest first, one
//   per cycle while the receiver keeps out_ready high; the first result is
//   loaded into the output register once the state has switched to emit.
//   end_of_run marks the smallest value, overflow is set on the whole run
//   if anything was dropped. the emit phase is paced by the single output
//   register. in_ready returns high once the last result is loaded into the
//   output register, so the next set can start while it still waits to be
//   taken. a stalled receiver holds out_data and pauses emission.
//   reset (rst_n low, synchronous) empties the stack and drops out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_insertion_sorter_unit #(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sis_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sis_pkg::out_item_t      out_data
);
  import sis_pkg::*;

  sis_cmd_t    cmd;
  sis_status_t status;

  sis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_final  (in_data.final_item),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sis_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .status   (status),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/sis_checker.sv =====
// ----------------------------------------------------------------------------
// sis_checker
// port-level checks for the stack insertion sorter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module sis_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire sis_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire sis_pkg::out_item_t out_data
);
  import sis_pkg::*;

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // closing transfer stops collection
  a_final_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.final_item) |=> !in_ready)
    else $error("input accepted right after closing transfer");

  // collection reopens only once the last result of the run is loaded
  a_eor_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_ready) |-> (out_valid && out_data.end_of_run))
    else $error("collection reopened before end of run");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind stack_insertion_sorter_unit sis_checker u_sis_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
